### hw/rtl/drmt_pkg.sv
package drmt_pkg;

   localparam int COORD_BITS = 16;
   localparam int CNT_W      = 5;
   localparam int MODE_W     = 2;

   localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd0;
   localparam logic [MODE_W-1:0] MODE_ADD   = 2'd1;
   localparam logic [MODE_W-1:0] MODE_READ  = 2'd2;
   localparam logic [MODE_W-1:0] MODE_RSVD  = 2'd3;

   typedef struct packed {
      logic signed [COORD_BITS-1:0] l;
      logic signed [COORD_BITS-1:0] t;
      logic signed [COORD_BITS-1:0] r;
      logic signed [COORD_BITS-1:0] b;
   } rect_type;

   typedef struct packed {
      logic [MODE_W-1:0]            mode;
      logic signed [COORD_BITS-1:0] new_left;
      logic signed [COORD_BITS-1:0] new_top;
      logic signed [COORD_BITS-1:0] new_right;
      logic signed [COORD_BITS-1:0] new_bottom;
   } req_type;

   typedef struct packed {
      logic signed [COORD_BITS-1:0] out_left;
      logic signed [COORD_BITS-1:0] out_top;
      logic signed [COORD_BITS-1:0] out_right;
      logic signed [COORD_BITS-1:0] out_bottom;
      logic                         entry_valid;
      logic [CNT_W-1:0]             entry_count;
      logic                         status;
      logic                         last;
   } rsp_type;

   // non-empty overlap of two boxes
   function automatic logic touches(input rect_type a, input rect_type b);
      logic signed [COORD_BITS-1:0] l, t, r, bo;
      begin
         l  = (a.l > b.l) ? a.l : b.l;
         t  = (a.t > b.t) ? a.t : b.t;
         r  = (a.r < b.r) ? a.r : b.r;
         bo = (a.b < b.b) ? a.b : b.b;
         return !((bo <= t) || (r <= l));
      end
   endfunction

   function automatic rect_type unite(input rect_type a, input rect_type b);
      rect_type u;
      begin
         u.l = (a.l < b.l) ? a.l : b.l;
         u.t = (a.t < b.t) ? a.t : b.t;
         u.r = (a.r > b.r) ? a.r : b.r;
         u.b = (a.b > b.b) ? a.b : b.b;
         return u;
      end
   endfunction

endpackage

### hw/rtl/drmt_store.sv
module drmt_store #(
   parameter int DEPTH = 16,
   parameter int IW    = 4
) (
   input  logic               clock,
   input  logic               wr_en,
   input  logic [IW-1:0]      wr_addr,
   input  drmt_pkg::rect_type wr_data,
   input  logic               rd_en,
   input  logic [IW-1:0]      rd_addr,
   output drmt_pkg::rect_type rd_data
);
   import drmt_pkg::*;

   rect_type mem [DEPTH];
   rect_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // read data holds until the next read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### hw/rtl/dirty_rect_merge_tracker.sv
// Dirty rectangle list tracker.
// req channel: one request per operation (clear, add, read); req_stall is
//   high while an operation is in progress, so requests are taken one at a time.
// rsp channel: clear, add and any other code give one response; read gives one
//   response per stored entry with last on the final one (one response with
//   entry_valid low when the list is empty).
// Add: repeated passes over the list; each entry checked takes a memory read
//   (S_SCAN_RD), then a compare/merge (S_SCAN_EV), and each pass closes in
//   S_SCAN_RD. A pass that merged anything is followed by another. When a
//   pass merges nothing on a full list, the new box is folded into the final
//   entry (status set). The store's registered read splits each check in two.
// Read: per entry, a memory read (S_OUT_RD), then an output load (S_OUT_SEND).
// Clear: the count is zeroed and the response is loaded from S_RESP.
// The response sits in an output register; a stall on rsp holds it and pauses
// the read stream. Reset empties the list; store contents are left as is.
module dirty_rect_merge_tracker #(
   parameter int MAX_RECTS = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  drmt_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output drmt_pkg::rsp_type rsp_data
);
   import drmt_pkg::*;

   localparam int IW = (MAX_RECTS > 1) ? $clog2(MAX_RECTS) : 1;
   localparam int CW = $clog2(MAX_RECTS + 1);

   typedef enum logic [6:0] {
      S_IDLE     = 7'b0000001,
      S_SCAN_RD  = 7'b0000010,
      S_SCAN_EV  = 7'b0000100,
      S_FOLD_EV  = 7'b0001000,
      S_RESP     = 7'b0010000,
      S_OUT_RD   = 7'b0100000,
      S_OUT_SEND = 7'b1000000
   } state_type;

   state_type state_ff, state_in;
   logic [CW-1:0] count_ff, count_in;
   logic [CW-1:0] rd_idx_ff, rd_idx_in;
   logic [CW-1:0] wr_idx_ff, wr_idx_in;
   logic          merged_ff, merged_in;
   logic          status_ff, status_in;
   rect_type      m_ff, m_in;
   rsp_type       rsp_ff, rsp_in;
   logic          rsp_valid_ff, rsp_valid_in;

   logic          mem_we, mem_re;
   logic [IW-1:0] mem_waddr, mem_raddr;
   rect_type      mem_wdata, mem_q;
   logic          req_take, out_free, hit;
   rect_type      req_rect;

   drmt_store #(.DEPTH(MAX_RECTS), .IW(IW)) u_store (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_en   (mem_re),
      .rd_addr (mem_raddr),
      .rd_data (mem_q)
   );

   assign req_stall = (state_ff != S_IDLE);
   assign req_take  = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   assign req_rect.l = req_data.new_left;
   assign req_rect.t = req_data.new_top;
   assign req_rect.r = req_data.new_right;
   assign req_rect.b = req_data.new_bottom;
   assign hit        = touches(mem_q, m_ff);

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      rd_idx_in    = rd_idx_ff;
      wr_idx_in    = wr_idx_ff;
      merged_in    = merged_ff;
      status_in    = status_ff;
      m_in         = m_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      mem_we       = 1'b0;
      mem_waddr    = wr_idx_ff[IW-1:0];
      mem_wdata    = m_ff;
      mem_re       = 1'b0;
      mem_raddr    = rd_idx_ff[IW-1:0];

      unique case (state_ff)
         S_IDLE: begin
            if (req_take) begin
               status_in = 1'b0;
               rd_idx_in = '0;
               wr_idx_in = '0;
               merged_in = 1'b0;
               m_in      = req_rect;
               case (req_data.mode)
                  MODE_CLEAR: begin
                     count_in = '0;
                     state_in = S_RESP;
                  end
                  MODE_ADD: state_in = S_SCAN_RD;
                  MODE_READ: state_in = (count_ff == '0) ? S_RESP : S_OUT_RD;
                  default: state_in = S_RESP;
               endcase
            end
         end
         S_SCAN_RD: begin
            if (rd_idx_ff == count_ff) begin
               // end of pass: survivors are packed below wr_idx
               count_in = wr_idx_ff;
               if (merged_ff) begin
                  rd_idx_in = '0;
                  wr_idx_in = '0;
                  merged_in = 1'b0;
               end else if (wr_idx_ff < CW'(MAX_RECTS)) begin
                  mem_we   = 1'b1;
                  count_in = wr_idx_ff + 1'b1;
                  state_in = S_RESP;
               end else begin
                  // full: fold into the final entry
                  mem_re    = 1'b1;
                  mem_raddr = IW'(MAX_RECTS - 1);
                  state_in  = S_FOLD_EV;
               end
            end else begin
               mem_re   = 1'b1;
               state_in = S_SCAN_EV;
            end
         end
         S_SCAN_EV: begin
            if (hit) begin
               m_in      = unite(m_ff, mem_q);
               merged_in = 1'b1;
            end else begin
               mem_we    = 1'b1;
               mem_wdata = mem_q;
               wr_idx_in = wr_idx_ff + 1'b1;
            end
            rd_idx_in = rd_idx_ff + 1'b1;
            state_in  = S_SCAN_RD;
         end
         S_FOLD_EV: begin
            mem_we    = 1'b1;
            mem_waddr = IW'(MAX_RECTS - 1);
            mem_wdata = unite(mem_q, m_ff);
            status_in = 1'b1;
            state_in  = S_RESP;
         end
         S_RESP: begin
            if (out_free) begin
               rsp_in             = '0;
               rsp_in.entry_count = CNT_W'(count_ff);
               rsp_in.status      = status_ff;
               rsp_in.last        = 1'b1;
               rsp_valid_in       = 1'b1;
               state_in           = S_IDLE;
            end
         end
         S_OUT_RD: begin
            mem_re   = 1'b1;
            state_in = S_OUT_SEND;
         end
         S_OUT_SEND: begin
            if (out_free) begin
               rsp_in.out_left    = mem_q.l;
               rsp_in.out_top     = mem_q.t;
               rsp_in.out_right   = mem_q.r;
               rsp_in.out_bottom  = mem_q.b;
               rsp_in.entry_valid = 1'b1;
               rsp_in.entry_count = CNT_W'(count_ff);
               rsp_in.status      = 1'b0;
               rsp_in.last        = (rd_idx_ff + 1'b1 == count_ff);
               rsp_valid_in       = 1'b1;
               rd_idx_in          = rd_idx_ff + 1'b1;
               state_in           = (rd_idx_ff + 1'b1 == count_ff) ? S_IDLE : S_OUT_RD;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         merged_ff    <= 1'b0;
         status_ff    <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         merged_ff    <= merged_in;
         status_ff    <= status_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_idx_ff <= rd_idx_in;
      wr_idx_ff <= wr_idx_in;
      m_ff      <= m_in;
      rsp_ff    <= rsp_in;
   end

   // list never grows past its capacity
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(MAX_RECTS))
      else $error("entry count above capacity");

   // compaction write pointer never passes the read pointer
   a_wr_behind_rd: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SCAN_RD || state_ff == S_SCAN_EV) |-> wr_idx_ff <= rd_idx_ff)
      else $error("compaction pointer ahead of scan");

   // an accepted request blocks further requests next cycle
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_take |=> req_stall)
      else $error("second request taken while busy");

   // a fold only happens on a full list
   a_fold_full: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_FOLD_EV) |-> count_ff == CW'(MAX_RECTS))
      else $error("fold on a list that is not full");

endmodule
